// ===== rtl/core/b32e_pkg.sv =====
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types and the character table of the Base32 byte encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  // One input beat: a message byte and its end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  // One result beat: an encoded character and its flags.
  typedef struct packed {
    logic [7:0] symbol_char;
    logic       final_symbol;
    logic       message_done;
  } out_item_t;

  localparam int unsigned SymW     = 5;
  localparam int unsigned MaxSyms  = 3;
  localparam int unsigned GroupW   = SymW * MaxSyms;
  localparam int unsigned CountW   = 2;

  // Work handed from the front to the back: up to three 5-bit groups packed
  // from the top, with zero fill below the last valid bit.
  typedef struct packed {
    logic [GroupW-1:0] groups;
    logic [CountW-1:0] count;
    logic              eom;
  } job_t;

  // Alphabet A-N, P-Z, 3-9.
  function automatic logic [7:0] sym_to_char(input logic [SymW-1:0] sym);
    logic [7:0] c;
    if (sym < 5'd14) begin
      c = 8'h41 + {3'd0, sym};
    end else if (sym < 5'd25) begin
      c = 8'h42 + {3'd0, sym};
    end else begin
      c = 8'h33 + {3'd0, sym} - 8'd25;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/base32_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// base32_byte_encoder
// Streaming Base32 encoder, alphabet A-N, P-Z, 3-9, no padding characters.
// ----------------------------------------------------------------------------
// Each accepted byte yields one or two characters, plus a flush character
// when it ends a message with bits left over. A byte is taken on any cycle
// the job queue has room, and its job passes through the job queue and the
// output register before its first character shows on the result ports.
// Characters leave at one per cycle through a single output register while
// the receiver pops, so a long message drains more slowly than it is taken;
// the QueueDepth job queue absorbs the difference between the two sides.
module base32_byte_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  b32e_pkg::in_item_t   in_data_i,
  output logic                 empty,
  input  logic                 pop,
  output b32e_pkg::out_item_t  out_data_o
);

  b32e_pkg::job_t new_job;
  b32e_pkg::job_t head_job;
  logic           accept;
  logic           queue_empty;
  logic           job_done;

  assign accept = push && !full;

  b32e_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .job_o    (new_job)
  );

  b32e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (new_job),
    .full_o   (full),
    .rd_i     (job_done),
    .rd_job_o (head_job),
    .empty_o  (queue_empty)
  );

  b32e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!queue_empty),
    .job_i       (head_job),
    .job_done_o  (job_done),
    .out_data_o  (out_data_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// ===== rtl/core/b32e_front.sv =====
// ----------------------------------------------------------------------------
// b32e_front
// Joins each accepted byte with the leftover bits and packs it into a job.
// ----------------------------------------------------------------------------
module b32e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  b32e_pkg::in_item_t  item_i,
  output b32e_pkg::job_t      job_o
);

  logic [3:0]  pending_bits_q, pending_bits_d;
  logic [2:0]  pending_count_q, pending_count_d;
  logic [3:0]  total;
  logic [3:0]  shift;
  logic [14:0] packed_w;
  logic        two_syms;
  logic [3:0]  rem_full;
  logic [2:0]  rem;
  logic [3:0]  rem_mask;
  logic        flush;

  always_comb begin
    total    = {1'b0, pending_count_q} + 4'd8;
    shift    = 4'd15 - total;
    // Left-align the live bits so the groups fall on fixed 5-bit slots.
    packed_w = {3'd0, pending_bits_q, item_i.data_byte} << shift;
    two_syms = (total >= 4'd10);
    rem_full = two_syms ? (total - 4'd10) : (total - 4'd5);
    rem      = rem_full[2:0];
    rem_mask = 4'((5'd1 << rem) - 5'd1);
    flush    = item_i.end_of_message && (rem != 3'd0);

    job_o.groups = packed_w;
    job_o.count  = (two_syms ? 2'd2 : 2'd1) + {1'b0, flush};
    job_o.eom    = item_i.end_of_message;

    if (item_i.end_of_message) begin
      pending_bits_d  = 4'd0;
      pending_count_d = 3'd0;
    end else begin
      pending_bits_d  = item_i.data_byte[3:0] & rem_mask;
      pending_count_d = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_bits_q  <= 4'd0;
      pending_count_q <= 3'd0;
    end else if (accept_i) begin
      pending_bits_q  <= pending_bits_d;
      pending_count_q <= pending_count_d;
    end
  end

endmodule

// ===== rtl/core/b32e_queue.sv =====
// ----------------------------------------------------------------------------
// b32e_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b32e_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  b32e_pkg::job_t  wr_job_i,
  output logic            full_o,
  input  logic            rd_i,
  output b32e_pkg::job_t  rd_job_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b32e_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o   = (cnt_q == CntW'(Depth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/b32e_back.sv =====
// ----------------------------------------------------------------------------
// b32e_back
// Steps through the groups of the head job and drives the output register.
// ----------------------------------------------------------------------------
module b32e_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  b32e_pkg::job_t       job_i,
  output logic                 job_done_o,
  output b32e_pkg::out_item_t  out_data_o,
  output logic                 empty_o,
  input  logic                 pop_i
);

  logic [1:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  b32e_pkg::out_item_t out_q, out_d;
  logic                load;
  logic                last;
  logic [4:0]          sym;

  always_comb begin
    load = job_valid_i && (!out_valid_q || pop_i);
    last = (idx_q == job_i.count - 2'd1);
    case (idx_q)
      2'd0:    sym = job_i.groups[14:10];
      2'd1:    sym = job_i.groups[9:5];
      2'd2:    sym = job_i.groups[4:0];
      default: sym = 5'd0;
    endcase

    out_d.symbol_char  = b32e_pkg::sym_to_char(sym);
    out_d.final_symbol = last;
    out_d.message_done = last && job_i.eom;

    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? 2'd0 : idx_q + 2'd1;
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign job_done_o = load && last;
  assign out_data_o = out_q;
  assign empty_o    = !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Base32 byte encoder: it streams whole messages
// into the input queue, predicts every character, and compares each popped
// beat against the predicted characters in order, with random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned DirectedBytes = 24;
  localparam int unsigned RandomBytes  = 146;
  localparam int unsigned QuietAfter   = DirectedBytes + 120;

  // Predicts the characters of each byte and checks them as they are popped.
  class b32_char_board;
    logic [3:0] held_bits;
    logic [2:0] held_count;
    b32e_pkg::out_item_t due_chars[$];
    int unsigned errors;

    function new();
      held_bits  = '0;
      held_count = '0;
      errors     = 0;
    endfunction

    function logic [7:0] letter_of(input logic [4:0] grp);
      string abc = "ABCDEFGHIJKLMNPQRSTUVWXYZ3456789";
      return abc[grp];
    endfunction

    function void take_byte(input b32e_pkg::in_item_t it);
      logic [11:0] acc;
      logic [4:0]  grps[3];
      int unsigned total;
      int unsigned n;
      b32e_pkg::out_item_t ch;
      acc   = {held_bits, it.data_byte};
      total = held_count + 8;
      n     = 0;
      while (total >= 5) begin
        total   = total - 5;
        grps[n] = 5'((acc >> total) & 12'h01f);
        n++;
      end
      acc = acc & ((12'd1 << total) - 12'd1);
      if (it.end_of_message) begin
        // Leftover bits are padded with zeros on the right into one more character.
        if (total > 0) begin
          grps[n] = 5'((acc << (5 - total)) & 12'h01f);
          n++;
        end
        held_bits  = '0;
        held_count = '0;
      end else begin
        held_bits  = acc[3:0];
        held_count = 3'(total);
      end
      for (int unsigned k = 0; k < n; k++) begin
        ch.symbol_char  = letter_of(grps[k]);
        ch.final_symbol = (k == n - 1);
        ch.message_done = (k == n - 1) && it.end_of_message;
        due_chars.push_back(ch);
      end
    endfunction

    function void check_char(input b32e_pkg::out_item_t got);
      b32e_pkg::out_item_t want;
      if (due_chars.size() == 0) begin
        $display("%0t: unexpected character beat %h", $time, got);
        errors++;
        return;
      end
      want = due_chars.pop_front();
      if (got.symbol_char !== want.symbol_char) begin
        $display("%0t: symbol_char expected %h actual %h", $time,
                 want.symbol_char, got.symbol_char);
        errors++;
      end
      if (got.final_symbol !== want.final_symbol) begin
        $display("%0t: final_symbol expected %b actual %b", $time,
                 want.final_symbol, got.final_symbol);
        errors++;
      end
      if (got.message_done !== want.message_done) begin
        $display("%0t: message_done expected %b actual %b", $time,
                 want.message_done, got.message_done);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic                empty;
  logic                pop;
  b32e_pkg::in_item_t  in_data_i;
  b32e_pkg::out_item_t out_data_o;

  b32_char_board board = new();
  bit            quiet_tail;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent;

  base32_byte_encoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Beats are noted and checked at the rising edge, before the edge takes effect.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        board.take_byte(in_data_i);
      end
      if (pop && !empty) begin
        board.check_char(out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("base32_byte_encoder test failed");
      $finish;
    end
  end

  // Receiver: pops every cycle except in random stall bursts.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic sender_gap();
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      push      <= 1'b0;
      in_data_i <= b32e_pkg::in_item_t'(9'($urandom));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input logic eom);
    sender_gap();
    @(negedge clk_i);
    push                     <= 1'b1;
    in_data_i.data_byte      <= data;
    in_data_i.end_of_message <= eom;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // The sender goes idle first so the last byte is not taken again.
  task automatic wait_for_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (board.due_chars.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned len;
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_data_i   = '0;
    quiet_tail  = 1'b0;
    bytes_sent  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Messages of one to five bytes walk the leftover count through every value;
    // the four-byte message ends with three characters and the five-byte one ends
    // with no leftover bits at all.
    for (int unsigned n = 1; n <= 5; n++) begin
      for (int unsigned i = 0; i < n; i++) begin
        send_byte((i % 2 == 0) ? 8'hff : 8'h00, i == n - 1);
      end
    end
    for (int unsigned i = 0; i < 4; i++) send_byte(8'ha5, i == 3);
    for (int unsigned i = 0; i < 5; i++) send_byte(8'h5a, i == 4);

    // Hold the sender off until the encoder has delivered everything.
    wait_for_drain();

    while (bytes_sent < DirectedBytes + RandomBytes) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      send_message(len);
      if (bytes_sent >= QuietAfter) begin
        quiet_tail = 1'b1;
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("base32_byte_encoder test passed");
    end else begin
      $display("base32_byte_encoder test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/b32e_pkg.sv
rtl/core/b32e_front.sv
rtl/core/b32e_queue.sv
rtl/core/b32e_back.sv
rtl/core/base32_byte_encoder.sv
tb/tb_top.sv
